@@ sv/fkr_pkg.sv @@
package fkr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 56;

  localparam int ADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_PORT_W = 56;
  localparam int POS_W      = 5;
  localparam int ENTRY_W    = 5;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  typedef enum logic [1:0] {
    STAT_STORED    = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_REMOVED   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [POS_W-1:0]     position;
    logic [ENTRY_W-1:0]   entry_count;
  } result_t;

endpackage

@@ sv/fkr_ram.sv @@
module fkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/fkr_ctrl.sv @@
module fkr_ctrl
  import fkr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_mode,
  input  key_t    in_key,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res,
  output logic    wr_en,
  output addr_t   wr_addr,
  output key_t    wr_data,
  output logic    rd_en,
  output addr_t   rd_addr,
  input  key_t    rd_data
);

  state_t  state, state_next;
  key_t    key, key_next;
  cnt_t    cnt, cnt_next;
  cnt_t    idx, idx_next;
  cnt_t    pidx, pidx_next;
  cnt_t    hit, hit_next;
  logic    pend, pend_next;
  result_t res_r, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
    end
    key   <= key_next;
    idx   <= idx_next;
    pidx  <= pidx_next;
    hit   <= hit_next;
    res_r <= res_next;
  end

  always_comb begin
    state_next = state;
    key_next   = key;
    cnt_next   = cnt;
    idx_next   = idx;
    pidx_next  = pidx;
    hit_next   = hit;
    pend_next  = pend;
    res_next   = res_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cnt[ADDR_W-1:0];
    wr_data    = key;
    rd_en      = 1'b0;
    rd_addr    = idx[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_next = in_key;
          if (in_mode == MODE_APPEND) begin
            if (cnt == CNT_W'(QUEUE_DEPTH)) begin
              res_next = '{STAT_FULL, '0, ENTRY_W'(cnt)};
            end else begin
              wr_en    = 1'b1;
              wr_addr  = cnt[ADDR_W-1:0];
              wr_data  = in_key;
              cnt_next = cnt + 1'b1;
              res_next = '{STAT_STORED, '0, ENTRY_W'(cnt + 1'b1)};
            end
            state_next = ST_DONE;
          end else begin
            idx_next   = '0;
            pend_next  = 1'b0;
            state_next = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (pend && rd_data == key) begin
          hit_next   = pidx;
          idx_next   = pidx + 1'b1;
          pend_next  = 1'b0;
          state_next = ST_SHIFT;
        end else if (idx < cnt) begin
          rd_en     = 1'b1;
          pend_next = 1'b1;
          pidx_next = idx;
          idx_next  = idx + 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          res_next   = '{STAT_NOT_FOUND, '0, ENTRY_W'(cnt)};
          state_next = ST_DONE;
        end
      end

      ST_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(pidx - 1'b1);
          wr_data = rd_data;
        end
        if (idx < cnt) begin
          rd_en     = 1'b1;
          pend_next = 1'b1;
          pidx_next = idx;
          idx_next  = idx + 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          cnt_next   = cnt - 1'b1;
          res_next   = '{STAT_REMOVED, POS_W'(hit) + POS_W'(1), ENTRY_W'(cnt - 1'b1)};
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("held count above depth");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> {1'b0, wr_addr} <= cnt)
    else $error("write beyond held entries");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> idx < cnt)
    else $error("read beyond held entries");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && state_next == ST_DONE) |=> cnt == $past(cnt) - 1'b1)
    else $error("remove did not drop count by one");
`endif

endmodule

@@ sv/fifo_with_keyed_remove_core.sv @@
// Ordered key queue with delete-by-key. A transfer with tuser 0 appends the key at the
// tail (status full and dropped when QUEUE_DEPTH keys are held); tuser 1 removes the
// first key equal to it counting from the head, closes the gap and reports its 1-based
// position, or reports not found. Keys live in a single-port-read, single-port-write
// RAM with no reset; only held entries are ever read. An append writes the key at the
// tail and registers its result. A remove reads one entry per cycle: it searches from
// the head, and on a match moves each entry behind it forward by one place; a miss is
// reported once every held entry has been read. The result then passes through the
// output register. One item is in work at a time; the next input is taken while the
// previous result waits in the output register.
module fifo_with_keyed_remove_core
  import fkr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [KEY_PORT_W-1:0]     s_axis_tdata,  // [55:0] plate_key
  input  logic                      s_axis_tuser,  // [0] mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // [4:0] position, [9:5] entry_count
  output logic [1:0]                m_axis_tuser   // [1:0] status
);

  logic    res_valid, res_ready;
  result_t res, out_r;
  logic    out_valid;
  logic    wr_en, rd_en;
  addr_t   wr_addr, rd_addr;
  key_t    wr_data, rd_data;

  fkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_key    (s_axis_tdata[KEY_BITS-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  fkr_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_r.status;
  assign m_axis_tdata  = {6'd0, out_r.entry_count, out_r.position};

endmodule
